>>> sv/best_fit_allocator_coalescing_defines.svh
// assertion macros for the best-fit allocator
`ifndef BEST_FIT_ALLOCATOR_COALESCING_DEFINES_SVH
`define BEST_FIT_ALLOCATOR_COALESCING_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define BFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> sv/bfa_pkg.sv
// types and codes shared by the best-fit allocator top level and its checker
package bfa_pkg;
  localparam int ADDR_BITS = 21;
  localparam int MAX_REQUESTS = 1024;

  localparam logic [2:0] ST_ALLOC   = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_FREED   = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_ALLOC,
    CMD_FREE,
    CMD_CLEAR
  } cmd_e_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HREAD,
    S_HWAIT,
    S_SCAN,
    S_APPLY,
    S_OUT
  } state_t;
endpackage

>>> sv/best_fit_allocator_coalescing.sv
// Best-fit allocator with coalescing over a row of segment cells.
// One item goes from its input transfer to its result transfer through these steps: the accept
// cycle, a history read and wait, a scan in which the cell row rotates one place a cycle past
// the first cell, an update, and the result cycle, which holds until the result is taken.
// The row is back in place after the full rotation. A pool_size write or reset starts a
// clearing pass over every entry of the history memory, during which no item is taken.
module best_fit_allocator_coalescing #(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [20:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // alloc_size[20:0], free_request[31:21]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // status[2:0], start_addr[23:3]
  output logic        m_tlast
);
  import bfa_pkg::*;
  localparam int IB = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int HB = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CB = $clog2(MAX_REQUESTS + 1);
  localparam int AB = ADDR_BITS;
  localparam logic [AB:0] POOL_MAX = (AB+1)'(1) << (AB - 1);

  assign m_tlast = 1'b1;

  state_t state, state_next;
  logic [AB-1:0] pool;
  logic [CB-1:0] req_cnt;
  logic [HB-1:0] clr_idx;
  logic clearing;
  logic func;
  logic [AB-1:0] want;
  logic [10:0] fr;
  logic [IB:0] pos;
  logic [2:0] status;
  logic [AB-1:0] addr;

  logic [AB-1:0] h_start [MAX_REQUESTS];
  logic [AB-1:0] h_len [MAX_REQUESTS];
  logic h_live [MAX_REQUESTS];
  logic [AB-1:0] hr_start, hr_len;
  logic hr_live;
  logic h_we;
  logic [HB-1:0] h_waddr, h_raddr;
  logic [AB-1:0] h_wstart, h_wlen;
  logic h_wlive;

  logic [AB-1:0] bs, bl;
  logic fr_ok;
  logic best_f, lo_f, hi_f, spare_f;
  logic [IB-1:0] best_i, lo_i, hi_i, spare_i;
  logic [AB-1:0] best_len, best_start, lo_len, hi_len;

  logic [MAX_SEGMENTS-1:0] c_valid;
  logic [AB-1:0] c_start [MAX_SEGMENTS];
  logic [AB-1:0] c_len [MAX_SEGMENTS];
  logic apply, scan_start, scan_shift;
  logic [IB-1:0] t_idx;
  logic t_set, t_clr, t_ws, t_wl;
  logic [AB-1:0] t_start, t_len;
  logic [IB-1:0] t2_idx;
  logic t2_clr;

  logic [AB-1:0] cur_start, cur_len;
  logic cur_valid;
  logic [IB-1:0] cur_i;
  logic [AB:0] cur_end;

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      localparam int NB = (g + 1) % MAX_SEGMENTS;
      logic ap;
      assign ap = apply || (t2_clr && (t2_idx == IB'(g)));
      bfa_cell #(.ADDR_BITS(AB), .IDX_BITS(IB)) u_cell (
        .clk, .rst, .my_idx(IB'(g)), .shift(scan_shift),
        .nb_valid(c_valid[NB]), .nb_start(c_start[NB]), .nb_len(c_len[NB]),
        .scan_start(scan_start), .init_valid(pool != '0), .init_len(pool), .apply(ap),
        .t_idx((t2_clr && t2_idx == IB'(g)) ? t2_idx : t_idx),
        .t_set_valid(t_set && !(t2_clr && t2_idx == IB'(g))),
        .t_clr_valid(t_clr || (t2_clr && t2_idx == IB'(g))),
        .t_wr_start(t_ws && !(t2_clr && t2_idx == IB'(g))),
        .t_wr_len(t_wl && !(t2_clr && t2_idx == IB'(g))),
        .t_start(t_start), .t_len(t_len),
        .valid(c_valid[g]), .seg_start(c_start[g]), .seg_len(c_len[g]));
    end
  endgenerate

  // cell 0 holds entry pos while the row rotates
  assign scan_shift = (state == S_SCAN);
  assign cur_i = pos[IB-1:0];
  assign cur_valid = c_valid[0];
  assign cur_start = c_start[0];
  assign cur_len = c_len[0];
  assign cur_end = {1'b0, cur_start} + {1'b0, cur_len};

  assign s_tready = (state == S_IDLE) && !clearing && !cfg_we;
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {addr, status};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid && s_tready) state_next = S_HREAD;
      S_HREAD: state_next = S_HWAIT;
      S_HWAIT: state_next = S_SCAN;
      S_SCAN:  if (pos == (IB+1)'(MAX_SEGMENTS - 1)) state_next = S_APPLY;
      S_APPLY: state_next = S_OUT;
      S_OUT:   if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign h_raddr = fr[HB-1:0] - HB'(1);
  always_ff @(posedge clk) begin
    if (h_we) begin
      h_start[h_waddr] <= h_wstart;
      h_len[h_waddr] <= h_wlen;
      h_live[h_waddr] <= h_wlive;
    end
    hr_start <= h_start[h_raddr];
    hr_len <= h_len[h_raddr];
    hr_live <= h_live[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool <= AB'(POOL_MAX);
      req_cnt <= '0;
      clearing <= 1'b1;
      clr_idx <= '0;
    end else if (cfg_we) begin
      pool <= ({1'b0, cfg_wdata[AB-1:0]} > POOL_MAX) ? AB'(POOL_MAX) : cfg_wdata[AB-1:0];
      req_cnt <= '0;
      clearing <= 1'b1;
      clr_idx <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + HB'(1);
        if (clr_idx == HB'(MAX_REQUESTS - 1)) clearing <= 1'b0;
      end
      if (state == S_APPLY && req_cnt < CB'(MAX_REQUESTS)) req_cnt <= req_cnt + CB'(1);
    end
  end

  assign scan_start = clearing && (clr_idx == '0);

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid && s_tready) begin
      func <= s_tuser;
      want <= s_tdata[AB-1:0];
      fr <= s_tdata[31:21];
    end
    if (state == S_HWAIT) begin
      pos <= '0;
      best_f <= 1'b0; lo_f <= 1'b0; hi_f <= 1'b0; spare_f <= 1'b0;
      best_i <= '0; lo_i <= '0; hi_i <= '0; spare_i <= '0;
      best_len <= '0; best_start <= '0; lo_len <= '0; hi_len <= '0;
      bs <= hr_start;
      bl <= hr_len;
      fr_ok <= (fr != '0) && (CB'(fr) <= req_cnt) && hr_live;
    end
    if (state == S_SCAN) begin
      pos <= pos + (IB+1)'(1);
      if (!cur_valid) begin
        if (!spare_f) begin spare_f <= 1'b1; spare_i <= cur_i; end
      end else begin
        if (cur_len >= want && (!best_f || cur_len < best_len ||
            (cur_len == best_len && cur_start < best_start))) begin
          best_f <= 1'b1; best_i <= cur_i; best_len <= cur_len; best_start <= cur_start;
        end
        if (cur_end == {1'b0, bs}) begin lo_f <= 1'b1; lo_i <= cur_i; lo_len <= cur_len; end
        if ({1'b0, cur_start} == {1'b0, bs} + {1'b0, bl}) begin
          hi_f <= 1'b1; hi_i <= cur_i; hi_len <= cur_len;
        end
      end
    end
  end

  logic rec;
  assign rec = req_cnt < CB'(MAX_REQUESTS);

  always_comb begin
    apply = 1'b0; t_idx = '0; t_set = 1'b0; t_clr = 1'b0; t_ws = 1'b0; t_wl = 1'b0;
    t_start = '0; t_len = '0; t2_idx = '0; t2_clr = 1'b0;
    h_we = 1'b0; h_waddr = req_cnt[HB-1:0]; h_wstart = '0; h_wlen = '0; h_wlive = 1'b0;
    if (clearing) begin
      h_we = 1'b1; h_waddr = clr_idx;
    end else if (state == S_APPLY) begin
      if (func == FUNC_ALLOC) begin
        if (rec && want != '0 && best_f) begin
          apply = 1'b1; t_idx = best_i;
          if (best_len == want) t_clr = 1'b1;
          else begin
            t_ws = 1'b1; t_wl = 1'b1; t_start = best_start + want; t_len = best_len - want;
          end
        end
        h_we = rec; h_wstart = (rec && want != '0 && best_f) ? best_start : '0;
        h_wlen = want; h_wlive = rec && want != '0 && best_f;
      end else begin
        if (fr_ok) begin
          if (lo_f) begin
            apply = 1'b1; t_idx = lo_i; t_wl = 1'b1;
            t_len = lo_len + bl + (hi_f ? hi_len : '0);
            t2_clr = hi_f; t2_idx = hi_i;
          end else if (hi_f) begin
            apply = 1'b1; t_idx = hi_i; t_ws = 1'b1; t_wl = 1'b1;
            t_start = bs; t_len = hi_len + bl;
          end else if (spare_f) begin
            apply = 1'b1; t_idx = spare_i; t_set = 1'b1; t_ws = 1'b1; t_wl = 1'b1;
            t_start = bs; t_len = bl;
          end
        end
        h_we = rec;
      end
    end else if (state == S_OUT && func == FUNC_FREE && status == ST_FREED) begin
      h_we = 1'b1; h_waddr = h_raddr; h_wstart = bs; h_wlen = bl; h_wlive = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      addr <= '0;
      if (func == FUNC_ALLOC) begin
        if (rec && want != '0 && best_f) begin status <= ST_ALLOC; addr <= best_start; end
        else status <= ST_NOFIT;
      end else if (!fr_ok) status <= ST_IGNORED;
      else if (lo_f || hi_f || spare_f) status <= ST_FREED;
      else status <= ST_FULL;
    end
  end
endmodule

>>> sv/bfa_cell.sv
// one segment cell: holds a free segment and hands it to its neighbor while the row rotates
module bfa_cell #(
  parameter int ADDR_BITS = 21,
  parameter int IDX_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IDX_BITS-1:0]  my_idx,
  input  logic                 shift,
  input  logic                 nb_valid,
  input  logic [ADDR_BITS-1:0] nb_start,
  input  logic [ADDR_BITS-1:0] nb_len,
  input  logic                 scan_start,
  input  logic                 init_valid,
  input  logic [ADDR_BITS-1:0] init_len,
  input  logic                 apply,
  input  logic [IDX_BITS-1:0]  t_idx,
  input  logic                 t_set_valid,
  input  logic                 t_clr_valid,
  input  logic                 t_wr_start,
  input  logic                 t_wr_len,
  input  logic [ADDR_BITS-1:0] t_start,
  input  logic [ADDR_BITS-1:0] t_len,
  output logic                 valid,
  output logic [ADDR_BITS-1:0] seg_start,
  output logic [ADDR_BITS-1:0] seg_len
);
  logic hit;
  assign hit = (t_idx == my_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (scan_start) begin
      if (my_idx == '0) valid <= init_valid;
      else valid <= 1'b0;
    end else if (shift) begin
      valid <= nb_valid;
    end else if (apply && hit) begin
      if (t_set_valid) valid <= 1'b1;
      else if (t_clr_valid) valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start && my_idx == '0) begin
      seg_start <= ADDR_BITS'(1);
      seg_len <= init_len;
    end else if (shift) begin
      seg_start <= nb_start;
      seg_len <= nb_len;
    end else begin
      if (apply && hit && t_wr_start) seg_start <= t_start;
      if (apply && hit && t_wr_len) seg_len <= t_len;
    end
  end
endmodule

>>> sv/bfa_checker.sv
// port-level checker for the best-fit allocator, bound to the top level
`include "best_fit_allocator_coalescing_defines.svh"
module bfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);
  import bfa_pkg::*;
  `BFA_ASSERT_IMP(a_no_take_busy, m_tvalid, !s_tready)
  `BFA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `BFA_ASSERT_IMP(a_addr_zero, m_tvalid && m_tdata[2:0] != ST_ALLOC, m_tdata[23:3] == 21'd0)
  `BFA_ASSERT_IMP(a_status_range, m_tvalid, m_tdata[2:0] <= ST_FULL)
  `BFA_ASSERT_NEXT(a_no_early, s_tvalid && s_tready, !m_tvalid)
endmodule

bind best_fit_allocator_coalescing bfa_checker u_bfa_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata);
